// File: rtl/ddm_pkg.sv
// ============================================================================
// ddm_pkg
// Shared types, codes and helpers for the differential drive mixer.
// ============================================================================
package ddm_pkg;

	// Field widths
	localparam int DIR_W   = 3;
	localparam int LEVEL_W = 8;
	localparam int UNIT_W  = 12;
	localparam int DUTY_W  = 16;
	localparam int BASE_W  = UNIT_W + LEVEL_W;  // unit_step * level
	localparam int WIDE_W  = BASE_W + 1;        // base plus turn amount

	// Stream and config port widths
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 72;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 16;

	// Command direction codes
	localparam logic [DIR_W-1:0] DIR_STOP     = 3'd0;
	localparam logic [DIR_W-1:0] DIR_FWD      = 3'd1;
	localparam logic [DIR_W-1:0] DIR_BACK     = 3'd2;
	localparam logic [DIR_W-1:0] DIR_LEFT     = 3'd3;
	localparam logic [DIR_W-1:0] DIR_RIGHT    = 3'd4;
	localparam logic [DIR_W-1:0] DIR_STRAIGHT = 3'd5;

	// Stored drive direction
	localparam logic [1:0] DRIVE_STOP = 2'd0;
	localparam logic [1:0] DRIVE_FWD  = 2'd1;
	localparam logic [1:0] DRIVE_BACK = 2'd2;

	// Held turn
	localparam logic [1:0] TURN_NONE  = 2'd0;
	localparam logic [1:0] TURN_LEFT  = 2'd1;
	localparam logic [1:0] TURN_RIGHT = 2'd2;

	// Config register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_UNIT_STEP   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TURN_AMOUNT = 1'd1;

	// Reset values of the config registers
	localparam logic [UNIT_W-1:0] UNIT_STEP_RST   = 12'd750;
	localparam logic [DUTY_W-1:0] TURN_AMOUNT_RST = 16'd3750;

	// Resolved command handed from the command stage to the mixer
	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [1:0]         drive;
		logic [1:0]         turn;
	} ddm_cmd_t;

	// Result item, left forward duty in the lowest bits
	typedef struct packed {
		logic              moving;
		logic [DUTY_W-1:0] right_back_duty;
		logic [DUTY_W-1:0] right_fwd_duty;
		logic [DUTY_W-1:0] left_back_duty;
		logic [DUTY_W-1:0] left_fwd_duty;
	} ddm_result_t;

	// Clamp a wide duty to the 16-bit compare range
	function automatic logic [DUTY_W-1:0] sat_duty(input logic [WIDE_W-1:0] x);
		logic [DUTY_W-1:0] r;
		if (x[WIDE_W-1:DUTY_W] != '0) begin
			r = '1;
		end else begin
			r = x[DUTY_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/differential_drive_mixer_top.sv
// ============================================================================
// differential_drive_mixer_top
// Drive command to four-channel PWM duty mixer for a two-wheeled base.
// ============================================================================
// One command is taken per clock cycle unless the output stalls. Its result
// item passes three registers: a decode register that also updates the held
// drive, speed and turn, a register after the unit_step * level multiply,
// and the output register after turn mixing and saturation. Results are one
// per command, in order; a stalled output backs up through the three stages,
// so up to three commands are in flight. Config writes are always taken and
// act at once; write them only while no command is in flight.
// ============================================================================
module differential_drive_mixer_top import ddm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// Command stream
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [2:0] direction, [10:3] level
	// Result stream
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [15:0] left_fwd_duty,
	                                              // [31:16] left_back_duty,
	                                              // [47:32] right_fwd_duty,
	                                              // [63:48] right_back_duty,
	                                              // [64] moving
	// Config write
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [UNIT_W-1:0] unit_step_q;
	logic [DUTY_W-1:0] turn_amount_q;
	logic              cmd_valid;
	logic              cmd_ready;
	ddm_cmd_t          cmd;
	ddm_result_t       res;

	// Config registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_step_q   <= UNIT_STEP_RST;
			turn_amount_q <= TURN_AMOUNT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_UNIT_STEP:   unit_step_q   <= cfg_data[UNIT_W-1:0];
				CFG_TURN_AMOUNT: turn_amount_q <= cfg_data[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	ddm_cmd u_cmd (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.direction (s_axis_tdata[DIR_W-1:0]),
		.level     (s_axis_tdata[DIR_W +: LEVEL_W]),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	ddm_mix u_mix (
		.clk         (clk),
		.arst_n      (arst_n),
		.unit_step   (unit_step_q),
		.turn_amount (turn_amount_q),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd),
		.res_valid   (m_axis_tvalid),
		.res_ready   (m_axis_tready),
		.res         (res)
	);

	assign m_axis_tdata = {(OUT_TDATA_W - $bits(ddm_result_t))'(0), res};

endmodule

// File: rtl/ddm_cmd.sv
// ============================================================================
// ddm_cmd
// Command decode: normalizes a command, updates the held drive, speed and
// turn, and registers the resolved command for the mixer.
// ============================================================================
module ddm_cmd import ddm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [DIR_W-1:0]   direction,
	input  logic [LEVEL_W-1:0] level,
	output logic               cmd_valid,
	input  logic               cmd_ready,
	output ddm_cmd_t           cmd
);

	logic [1:0]         drive_q;
	logic [1:0]         turn_q;
	logic [LEVEL_W-1:0] speed_q;
	logic [1:0]         drive_nx;
	logic [1:0]         turn_nx;
	logic [LEVEL_W-1:0] speed_nx;
	logic [DIR_W-1:0]   dir_n;
	logic               accept;
	logic               valid_s1;
	ddm_cmd_t           cmd_s1;

	assign in_ready = !valid_s1 || cmd_ready;
	assign accept   = in_valid && in_ready;

	// Normalize and resolve the next held state
	always_comb begin
		dir_n = direction;
		if (level == '0) begin
			if (direction inside {DIR_LEFT, DIR_RIGHT, DIR_STRAIGHT}) begin
				dir_n = DIR_STRAIGHT;
			end else begin
				dir_n = DIR_STOP;
			end
		end

		drive_nx = drive_q;
		speed_nx = speed_q;
		turn_nx  = turn_q;
		case (dir_n)
			DIR_FWD: begin
				drive_nx = DRIVE_FWD;
				speed_nx = level;
			end
			DIR_BACK: begin
				drive_nx = DRIVE_BACK;
				speed_nx = level;
			end
			DIR_STOP: begin
				drive_nx = DRIVE_STOP;
				speed_nx = '0;
			end
			default: ;
		endcase

		case (dir_n)
			DIR_LEFT:     turn_nx = TURN_LEFT;
			DIR_RIGHT:    turn_nx = TURN_RIGHT;
			DIR_STRAIGHT: turn_nx = TURN_NONE;
			default: ;
		endcase
	end

	// Held state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q <= DRIVE_STOP;
			turn_q  <= TURN_NONE;
			speed_q <= '0;
		end else if (accept) begin
			drive_q <= drive_nx;
			turn_q  <= turn_nx;
			speed_q <= speed_nx;
		end
	end

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.level <= speed_nx;
			cmd_s1.drive <= drive_nx;
			cmd_s1.turn  <= turn_nx;
		end
	end

	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

	// A stopped drive always goes with a cleared speed, and only then
	a_speed_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(drive_q == DRIVE_STOP) == (speed_q == '0))
		else $error("held speed and drive direction disagree");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted command not held in stage 1");

	a_cmd_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ((cmd_s1.drive == DRIVE_STOP) == (cmd_s1.level == '0)))
		else $error("stage 1 level and drive disagree");

endmodule

// File: rtl/ddm_mix.sv
// ============================================================================
// ddm_mix
// Duty mixer: scales the level by the unit step, then applies the held
// turn, saturates and registers the result item.
// ============================================================================
module ddm_mix import ddm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [UNIT_W-1:0] unit_step,
	input  logic [DUTY_W-1:0] turn_amount,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  ddm_cmd_t          cmd,
	output logic              res_valid,
	input  logic              res_ready,
	output ddm_result_t       res
);

	logic              valid_s2;
	logic [BASE_W-1:0] base_s2;
	logic [1:0]        drive_s2;
	logic [1:0]        turn_s2;
	logic              out_valid_q;
	ddm_result_t       out_q;
	ddm_result_t       res_nx;
	logic              s2_ready;
	logic              out_ready;
	logic [WIDE_W-1:0] outer;
	logic [BASE_W-1:0] inner;
	logic [DUTY_W-1:0] spill;
	logic [DUTY_W-1:0] outer_sat;
	logic [DUTY_W-1:0] inner_sat;
	logic [DUTY_W-1:0] base_sat;
	logic              short_base;
	logic              back;

	assign out_ready = !out_valid_q || res_ready;
	assign s2_ready  = !valid_s2 || out_ready;
	assign cmd_ready = s2_ready;

	// Stage 2: base duty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && cmd_valid) begin
			base_s2  <= BASE_W'(unit_step) * BASE_W'(cmd.level);
			drive_s2 <= cmd.drive;
			turn_s2  <= cmd.turn;
		end
	end

	// Turn mixing on the base duty
	always_comb begin
		outer      = {1'b0, base_s2} + WIDE_W'(turn_amount);
		short_base = BASE_W'(turn_amount) > base_s2;
		inner      = short_base ? '0 : base_s2 - BASE_W'(turn_amount);
		spill      = short_base ? turn_amount - base_s2[DUTY_W-1:0] : '0;
		outer_sat  = sat_duty(outer);
		inner_sat  = sat_duty({1'b0, inner});
		base_sat   = sat_duty({1'b0, base_s2});
		back       = (drive_s2 == DRIVE_BACK);

		res_nx = '0;
		case (turn_s2)
			TURN_LEFT: begin
				if (back) begin
					res_nx.right_back_duty = outer_sat;
					res_nx.left_back_duty  = inner_sat;
					res_nx.left_fwd_duty   = spill;
				end else begin
					res_nx.right_fwd_duty = outer_sat;
					res_nx.left_fwd_duty  = inner_sat;
					res_nx.left_back_duty = spill;
				end
			end
			TURN_RIGHT: begin
				if (back) begin
					res_nx.left_back_duty  = outer_sat;
					res_nx.right_back_duty = inner_sat;
					res_nx.right_fwd_duty  = spill;
				end else begin
					res_nx.left_fwd_duty   = outer_sat;
					res_nx.right_fwd_duty  = inner_sat;
					res_nx.right_back_duty = spill;
				end
			end
			default: begin
				case (drive_s2)
					DRIVE_FWD: begin
						res_nx.left_fwd_duty  = base_sat;
						res_nx.right_fwd_duty = base_sat;
					end
					DRIVE_BACK: begin
						res_nx.left_back_duty  = base_sat;
						res_nx.right_back_duty = base_sat;
					end
					default: ;
				endcase
			end
		endcase
		res_nx.moving = (drive_s2 != DRIVE_STOP) || (turn_s2 != TURN_NONE);
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && valid_s2) begin
			out_q <= res_nx;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.moving) |->
		(out_q.left_fwd_duty == '0 && out_q.left_back_duty == '0 &&
		 out_q.right_fwd_duty == '0 && out_q.right_back_duty == '0))
		else $error("duty driven while not moving");

	a_left_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.left_fwd_duty == '0 || out_q.left_back_duty == '0))
		else $error("left wheel driven both ways");

	a_right_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.right_fwd_duty == '0 || out_q.right_back_duty == '0))
		else $error("right wheel driven both ways");

endmodule
